### hw/rtl/keyed_histogram_counter_core_defines.svh
// Assertion macros used by the checker file of the histogram counter.
`ifndef KEYED_HISTOGRAM_COUNTER_CORE_DEFINES_SVH
`define KEYED_HISTOGRAM_COUNTER_CORE_DEFINES_SVH

// Property checked at every rising edge outside reset.
`define KHC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("histogram counter check failed");

// Property checked at every rising edge, reset included.
`define KHC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("histogram counter check failed");

`endif

### hw/rtl/khc_pkg.sv
// Shared constants and types of the keyed histogram counter.
`timescale 1ns / 1ps
`default_nettype none

package khc_pkg;

  localparam int NUM_BINS_DEFAULT = 4096;
  localparam int COUNT_W          = 31;
  localparam int KEY_W            = 32;
  localparam int CFG_W            = 13;

  localparam logic [CFG_W-1:0] BINS_IN_USE_RESET = 13'd4096;

  // Opcode codes carried in the input tuser bit.
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Control bits of the item held in the update stage.
  typedef struct packed {
    logic opcode;
    logic key_error;
  } item_t;

endpackage

`default_nettype wire

### hw/rtl/khc_bin_ram.sv
// Bin store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module khc_bin_ram #(
  parameter int DEPTH = khc_pkg::NUM_BINS_DEFAULT,
  parameter int AW    = $clog2(khc_pkg::NUM_BINS_DEFAULT)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [khc_pkg::COUNT_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [khc_pkg::COUNT_W-1:0] rdata
);

  logic [khc_pkg::COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-first: a read at the address written in the same cycle sees the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/khc_update.sv
// Update stage: forwards the last write, increments with saturation, writes back.
`timescale 1ns / 1ps
`default_nettype none

module khc_update #(
  parameter int AW = $clog2(khc_pkg::NUM_BINS_DEFAULT)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire khc_pkg::item_t              load_item,
  input  wire logic [AW-1:0]               load_addr,
  input  wire logic                        adv,
  input  wire logic [khc_pkg::COUNT_W-1:0] rdata,
  output logic                             busy,
  output khc_pkg::item_t                   item,
  output logic      [khc_pkg::COUNT_W-1:0] result,
  output logic                             we,
  output logic      [AW-1:0]               waddr,
  output logic      [khc_pkg::COUNT_W-1:0] wdata
);

  logic [AW-1:0]               addr;
  logic                        fwd_valid;
  logic [AW-1:0]               fwd_addr;
  logic [khc_pkg::COUNT_W-1:0] fwd_data;
  logic [khc_pkg::COUNT_W-1:0] cur;
  logic [khc_pkg::COUNT_W-1:0] incr;
  logic                        is_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (adv) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= load_item;
      addr <= load_addr;
    end
  end

  // The read of this item was issued at the edge that wrote the previous
  // item's count, so that one write is taken from here instead of the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (adv) begin
      fwd_valid <= we;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_addr <= waddr;
      fwd_data <= wdata;
    end
  end

  always_comb begin
    cur      = (fwd_valid && fwd_addr == addr) ? fwd_data : rdata;
    incr     = (&cur) ? cur : cur + khc_pkg::COUNT_W'(1);
    is_count = (item.opcode == khc_pkg::OP_COUNT);
    if (item.key_error) begin
      result = '0;
    end else if (is_count) begin
      result = incr;
    end else begin
      result = cur;
    end
    we    = busy && adv && !item.key_error && is_count;
    waddr = addr;
    wdata = incr;
  end

endmodule

`default_nettype wire

### hw/rtl/keyed_histogram_counter_core.sv
// Keyed histogram counter: one item per cycle outside the clearing pass, while the
// output is not stalled. The bin store reads at the accept edge and the update stage
// writes back as it advances; a one-entry forward covers back-to-back same-bin keys.
// After reset a clearing pass zeroes all NUM_BINS bins of the store, one bin a cycle;
// s_axis_tready stays low meanwhile while configuration writes are still taken.
// Reset sets bins_in_use to 4096 and empties the update stage and the output register.
`timescale 1ns / 1ps
`default_nettype none

module keyed_histogram_counter_core #(
  parameter int NUM_BINS = khc_pkg::NUM_BINS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data,       // bins_in_use
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] key (signed)
  input  wire logic [0:0]  s_axis_tuser,   // [0] opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [30:0] bin_count, [31] zero pad
  output logic [0:0]       m_axis_tuser    // [0] key_error
);

  localparam int AW = $clog2(NUM_BINS);

  logic [khc_pkg::CFG_W-1:0]   bins_in_use;
  logic                        clearing;
  logic [AW-1:0]               clr_addr;
  logic                        in_accept;
  logic                        key_ok;
  khc_pkg::item_t              in_item;
  logic                        upd_busy;
  logic                        upd_adv;
  khc_pkg::item_t              upd_item;
  logic [khc_pkg::COUNT_W-1:0] upd_result;
  logic                        upd_we;
  logic [AW-1:0]               upd_waddr;
  logic [khc_pkg::COUNT_W-1:0] upd_wdata;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [khc_pkg::COUNT_W-1:0] ram_wdata;
  logic [khc_pkg::COUNT_W-1:0] ram_rdata;
  logic [khc_pkg::COUNT_W-1:0] out_count;
  logic                        out_error;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= khc_pkg::BINS_IN_USE_RESET;
    end else if (cfg_valid) begin
      bins_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(NUM_BINS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    key_ok = !s_axis_tdata[31]
             && (s_axis_tdata[30:0] < 31'(bins_in_use))
             && (s_axis_tdata[30:0] < 31'(NUM_BINS));
    in_item.opcode    = s_axis_tuser[0];
    in_item.key_error = !key_ok;
  end

  assign upd_adv       = upd_busy && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !clearing && (!upd_busy || upd_adv);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign ram_we    = clearing || upd_we;
  assign ram_waddr = clearing ? clr_addr : upd_waddr;
  assign ram_wdata = clearing ? '0 : upd_wdata;

  khc_bin_ram #(
    .DEPTH (NUM_BINS),
    .AW    (AW)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (s_axis_tdata[AW-1:0]),
    .rdata (ram_rdata)
  );

  khc_update #(
    .AW (AW)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept),
    .load_item (in_item),
    .load_addr (s_axis_tdata[AW-1:0]),
    .adv       (upd_adv),
    .rdata     (ram_rdata),
    .busy      (upd_busy),
    .item      (upd_item),
    .result    (upd_result),
    .we        (upd_we),
    .waddr     (upd_waddr),
    .wdata     (upd_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (upd_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_adv) begin
      out_count <= upd_result;
      out_error <= upd_item.key_error;
    end
  end

  assign m_axis_tdata = {1'b0, out_count};
  assign m_axis_tuser = out_error;

endmodule

`default_nettype wire

### hw/rtl/khc_checker.sv
// Port-level checks of the histogram counter and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_histogram_counter_core_defines.svh"

module khc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // The clearing pass keeps the input closed right after reset.
  `KHC_ASSERT_ALWAYS(a_closed_after_reset, clk, rst |=> !s_axis_tready)

  // A rejected key never reports a count.
  `KHC_ASSERT(a_error_zero_count, clk, rst,
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))

  // Counts saturate within 31 bits, so the pad bit stays clear.
  `KHC_ASSERT(a_pad_bit_clear, clk, rst, m_axis_tvalid |-> !m_axis_tdata[31])

  `KHC_ASSERT(a_stalled_result_holds, clk, rst,
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

endmodule

bind keyed_histogram_counter_core khc_checker u_khc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
